@@ rtl/core/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg
// Types and fixed widths shared by the triangle scanline span pipeline.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int CoordBits = 12;
    localparam int DepthBits = 24;
    localparam int FracBits  = 8;
    // quotient bits needed by both the x and the depth divisions
    localparam int QuoBits   = (CoordBits + FracBits > DepthBits) ?
                               (CoordBits + FracBits) : DepthBits;
    localparam int NumBits   = CoordBits + QuoBits;

    typedef struct packed {
        logic signed [CoordBits-1:0] vertex0_x;
        logic signed [CoordBits-1:0] vertex0_y;
        logic        [DepthBits-1:0] vertex0_depth;
        logic signed [CoordBits-1:0] vertex1_x;
        logic signed [CoordBits-1:0] vertex1_y;
        logic        [DepthBits-1:0] vertex1_depth;
        logic signed [CoordBits-1:0] vertex2_x;
        logic signed [CoordBits-1:0] vertex2_y;
        logic        [DepthBits-1:0] vertex2_depth;
        logic signed [CoordBits-1:0] scan_row;
    } t_in_word;

    typedef struct packed {
        logic                        row_inside;
        logic signed [CoordBits-1:0] edge_a_x;
        logic signed [CoordBits-1:0] edge_b_x;
        logic        [DepthBits-1:0] edge_a_depth;
        logic        [DepthBits-1:0] edge_b_depth;
        logic                        degenerate;
    } t_out_word;

    typedef struct packed {
        logic signed [CoordBits-1:0] x;
        logic signed [CoordBits-1:0] y;
        logic        [DepthBits-1:0] dep;
    } t_vtx;

    typedef struct packed {
        logic signed [CoordBits-1:0] xs;
        logic signed [CoordBits:0]   dx;
        logic        [DepthBits-1:0] ds;
        logic signed [DepthBits:0]   dd;
        logic        [CoordBits-1:0] h;
    } t_edge;

    typedef struct packed {
        logic                        vld;
        logic                        on_row;
        logic                        degen;
        logic                        swap;
        logic        [CoordBits-1:0] d;
        t_edge                       ea;
        t_edge                       eb;
    } t_setup;

    typedef struct packed {
        logic                        on_row;
        logic                        degen;
        logic                        swap;
        logic signed [CoordBits-1:0] xs_a;
        logic signed [CoordBits-1:0] xs_b;
        logic        [DepthBits-1:0] ds_a;
        logic        [DepthBits-1:0] ds_b;
        logic                        nx_a;
        logic                        nx_b;
        logic                        nd_a;
        logic                        nd_b;
    } t_meta;

endpackage

@@ rtl/core/tss_div.sv @@
// ----------------------------------------------------------------------------
// tss_div
// Pipelined restoring divider, one quotient bit per register stage.
// The upper DenW bits of the numerator must be below the divisor.
// ----------------------------------------------------------------------------
module tss_div #(
    parameter int DenW = 12,
    parameter int QuoW = 24
) (
    input  logic                   i_clk,
    input  logic [DenW+QuoW-1:0]   i_num,
    input  logic [DenW-1:0]        i_den,
    output logic [QuoW-1:0]        o_quo
);

    logic [DenW-1:0] r_rem [QuoW];
    logic [DenW-1:0] r_den [QuoW];
    logic [QuoW-1:0] r_low [QuoW];
    logic [QuoW-1:0] r_quo [QuoW];

    for (genvar i = 0; i < QuoW; i++) begin : g_step
        logic [DenW-1:0] rem_in;
        logic [DenW-1:0] den_in;
        logic [QuoW-1:0] low_in;
        logic [QuoW-1:0] quo_in;
        logic [DenW:0]   trial;
        logic [DenW:0]   diff;
        logic [DenW-1:0] n_rem;
        logic            qbit;

        if (i == 0) begin : g_first
            assign rem_in = i_num[DenW+QuoW-1:QuoW];
            assign low_in = i_num[QuoW-1:0];
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[i-1];
            assign low_in = r_low[i-1];
            assign den_in = r_den[i-1];
            assign quo_in = r_quo[i-1];
        end

        always_comb begin
            trial = {rem_in, low_in[QuoW-1]};
            diff  = trial - {1'b0, den_in};
            qbit  = (trial >= {1'b0, den_in});
            n_rem = qbit ? diff[DenW-1:0] : trial[DenW-1:0];
        end

        always_ff @(posedge i_clk) begin
            r_rem[i] <= n_rem;
            r_den[i] <= den_in;
            r_low[i] <= {low_in[QuoW-2:0], 1'b0};
            r_quo[i] <= {quo_in[QuoW-2:0], qbit};
        end
    end

    assign o_quo = r_quo[QuoW-1];

endmodule

@@ rtl/core/tss_setup.sv @@
// ----------------------------------------------------------------------------
// tss_setup
// Two stages: vertex sort by y, then half selection and edge set-up.
// ----------------------------------------------------------------------------
module tss_setup (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  tss_pkg::t_in_word i_word,
    output tss_pkg::t_setup   o_setup
);

    localparam int CB = tss_pkg::CoordBits;

    function automatic tss_pkg::t_edge make_edge(tss_pkg::t_vtx s, tss_pkg::t_vtx e,
                                                 logic [CB-1:0] h);
        tss_pkg::t_edge r;
        r.xs = s.x;
        r.dx = {e.x[CB-1], e.x} - {s.x[CB-1], s.x};
        r.ds = s.dep;
        r.dd = {1'b0, e.dep} - {1'b0, s.dep};
        r.h  = h;
        return r;
    endfunction

    // stage a: sort
    tss_pkg::t_vtx v0, v1, v2, lo, hi, sa, sb, sc, t;
    logic          all_eq;

    always_comb begin
        v0 = '{x: i_word.vertex0_x, y: i_word.vertex0_y, dep: i_word.vertex0_depth};
        v1 = '{x: i_word.vertex1_x, y: i_word.vertex1_y, dep: i_word.vertex1_depth};
        v2 = '{x: i_word.vertex2_x, y: i_word.vertex2_y, dep: i_word.vertex2_depth};
        all_eq = (v0.y == v1.y) && (v1.y == v2.y);
        lo = v0;
        if (v1.x < lo.x) begin
            lo = v1;
        end
        if (v2.x < lo.x) begin
            lo = v2;
        end
        hi = v0;
        if (v1.x > hi.x) begin
            hi = v1;
        end
        if (v2.x > hi.x) begin
            hi = v2;
        end
        sa = v0;
        sb = v1;
        sc = v2;
        t  = sa;
        if (sa.y > sb.y) begin
            t = sa; sa = sb; sb = t;
        end
        if (sb.y > sc.y) begin
            t = sb; sb = sc; sc = t;
        end
        if (sa.y > sb.y) begin
            t = sa; sa = sb; sb = t;
        end
    end

    logic                        r_a_vld;
    logic                        r_a_eq;
    tss_pkg::t_vtx               r_a_v0, r_a_v1, r_a_v2, r_a_lo, r_a_hi;
    logic signed [CB-1:0]        r_a_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
        end
        r_a_eq  <= all_eq;
        r_a_v0  <= sa;
        r_a_v1  <= sb;
        r_a_v2  <= sc;
        r_a_lo  <= lo;
        r_a_hi  <= hi;
        r_a_row <= i_word.scan_row;
    end

    // stage b: pick the half and both edges
    tss_pkg::t_setup  n_setup;
    logic             upper;
    logic signed [CB:0] d_up, d_lo, ha_up, ha_lo, hb;

    always_comb begin
        d_up  = {r_a_row[CB-1], r_a_row} - {r_a_v0.y[CB-1], r_a_v0.y};
        d_lo  = {r_a_v2.y[CB-1], r_a_v2.y} - {r_a_row[CB-1], r_a_row};
        ha_up = {r_a_v1.y[CB-1], r_a_v1.y} - {r_a_v0.y[CB-1], r_a_v0.y};
        ha_lo = {r_a_v2.y[CB-1], r_a_v2.y} - {r_a_v1.y[CB-1], r_a_v1.y};
        hb    = {r_a_v2.y[CB-1], r_a_v2.y} - {r_a_v0.y[CB-1], r_a_v0.y};
        upper = (r_a_v0.y < r_a_v1.y) && (r_a_row <= r_a_v1.y);
        n_setup.vld   = r_a_vld;
        n_setup.degen = r_a_eq;
        if (r_a_eq) begin
            // flat span: zero slopes so the edges come out at their start vertex
            n_setup.on_row = (r_a_row == r_a_v0.y);
            n_setup.swap   = 1'b0;
            n_setup.d      = '0;
            n_setup.ea     = make_edge(r_a_lo, r_a_lo, CB'(1));
            n_setup.eb     = make_edge(r_a_hi, r_a_hi, CB'(1));
        end else if (upper) begin
            n_setup.on_row = (r_a_row >= r_a_v0.y) && (r_a_row <= r_a_v2.y);
            n_setup.swap   = 1'b0;
            n_setup.d      = d_up[CB-1:0];
            n_setup.ea     = make_edge(r_a_v0, r_a_v1, ha_up[CB-1:0]);
            n_setup.eb     = make_edge(r_a_v0, r_a_v2, hb[CB-1:0]);
        end else begin
            n_setup.on_row = (r_a_row >= r_a_v0.y) && (r_a_row <= r_a_v2.y);
            n_setup.swap   = (r_a_v0.y == r_a_v1.y);
            n_setup.d      = d_lo[CB-1:0];
            n_setup.ea     = make_edge(r_a_v2, r_a_v1, ha_lo[CB-1:0]);
            n_setup.eb     = make_edge(r_a_v2, r_a_v0, hb[CB-1:0]);
        end
    end

    tss_pkg::t_setup r_setup;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup.vld <= 1'b0;
        end else begin
            r_setup.vld <= n_setup.vld;
        end
        r_setup.on_row <= n_setup.on_row;
        r_setup.degen  <= n_setup.degen;
        r_setup.swap   <= n_setup.swap;
        r_setup.d      <= n_setup.d;
        r_setup.ea     <= n_setup.ea;
        r_setup.eb     <= n_setup.eb;
    end

    assign o_setup = r_setup;

endmodule

@@ rtl/core/triangle_scanline_span_top.sv @@
// ----------------------------------------------------------------------------
// triangle_scanline_span_top
// Edge x and depth of one scanline across a triangle.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  command   in         start (busy low)    i_word  (tss_pkg::t_in_word)
//  result    out        o_strobe, one cycle o_word  (tss_pkg::t_out_word)
//
//  one word is taken every cycle; busy is always low
//  words pass the input register, set-up, multiply and numerator registers
//  and four pipelined dividers, one quotient bit per stage, to the output register
//  synchronous active-low reset clears only the valid bits of the pipeline
//  the receiver cannot stall, so the pipeline never holds
// ----------------------------------------------------------------------------
module triangle_scanline_span_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tss_pkg::t_in_word  i_word,
    output logic               o_strobe,
    output tss_pkg::t_out_word o_word
);

    localparam int CB = tss_pkg::CoordBits;
    localparam int DB = tss_pkg::DepthBits;
    localparam int FB = tss_pkg::FracBits;
    localparam int QB = tss_pkg::QuoBits;
    localparam int NB = tss_pkg::NumBits;
    localparam int XW = CB + FB + 2;

    assign busy = 1'b0;

    // input register
    logic              r_in_vld;
    tss_pkg::t_in_word r_in_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
        r_in_word <= i_word;
    end

    tss_pkg::t_setup setup;

    tss_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_word  (r_in_word),
        .o_setup (setup)
    );

    // multiply stage: slope magnitudes times row distance
    logic [CB:0] adx_a, adx_b;
    logic [DB:0] add_a, add_b;
    tss_pkg::t_meta n3_meta;

    always_comb begin
        adx_a = setup.ea.dx[CB] ? -setup.ea.dx : setup.ea.dx;
        adx_b = setup.eb.dx[CB] ? -setup.eb.dx : setup.eb.dx;
        add_a = setup.ea.dd[DB] ? -setup.ea.dd : setup.ea.dd;
        add_b = setup.eb.dd[DB] ? -setup.eb.dd : setup.eb.dd;
        n3_meta.on_row = setup.on_row;
        n3_meta.degen  = setup.degen;
        n3_meta.swap   = setup.swap;
        n3_meta.xs_a   = setup.ea.xs;
        n3_meta.xs_b   = setup.eb.xs;
        n3_meta.ds_a   = setup.ea.ds;
        n3_meta.ds_b   = setup.eb.ds;
        n3_meta.nx_a   = setup.ea.dx[CB];
        n3_meta.nx_b   = setup.eb.dx[CB];
        n3_meta.nd_a   = setup.ea.dd[DB];
        n3_meta.nd_b   = setup.eb.dd[DB];
    end

    logic              r3_vld;
    tss_pkg::t_meta    r3_meta;
    logic [2*CB-1:0]   r3_mx_a, r3_mx_b;
    logic [DB+CB-1:0]  r3_md_a, r3_md_b;
    logic [CB-1:0]     r3_h_a, r3_h_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= setup.vld;
        end
        r3_meta <= n3_meta;
        r3_mx_a <= adx_a[CB-1:0] * setup.d;
        r3_mx_b <= adx_b[CB-1:0] * setup.d;
        r3_md_a <= add_a[DB-1:0] * setup.d;
        r3_md_b <= add_b[DB-1:0] * setup.d;
        r3_h_a  <= setup.ea.h;
        r3_h_b  <= setup.eb.h;
    end

    // numerator stage: x gets its fraction bits, depth gets half a step for rounding
    logic           r4_vld;
    tss_pkg::t_meta r4_meta;
    logic [NB-1:0]  r4_nx_a, r4_nx_b, r4_nd_a, r4_nd_b;
    logic [CB-1:0]  r4_h_a, r4_h_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_meta <= r3_meta;
        r4_nx_a <= NB'(r3_mx_a) << FB;
        r4_nx_b <= NB'(r3_mx_b) << FB;
        r4_nd_a <= NB'(r3_md_a) + NB'(r3_h_a >> 1);
        r4_nd_b <= NB'(r3_md_b) + NB'(r3_h_b >> 1);
        r4_h_a  <= r3_h_a;
        r4_h_b  <= r3_h_b;
    end

    logic [QB-1:0] q_xa, q_xb, q_da, q_db;

    tss_div #(.DenW(CB), .QuoW(QB)) u_div_xa (
        .i_clk (i_clk), .i_num (r4_nx_a), .i_den (r4_h_a), .o_quo (q_xa)
    );
    tss_div #(.DenW(CB), .QuoW(QB)) u_div_xb (
        .i_clk (i_clk), .i_num (r4_nx_b), .i_den (r4_h_b), .o_quo (q_xb)
    );
    tss_div #(.DenW(CB), .QuoW(QB)) u_div_da (
        .i_clk (i_clk), .i_num (r4_nd_a), .i_den (r4_h_a), .o_quo (q_da)
    );
    tss_div #(.DenW(CB), .QuoW(QB)) u_div_db (
        .i_clk (i_clk), .i_num (r4_nd_b), .i_den (r4_h_b), .o_quo (q_db)
    );

    // side data delayed alongside the dividers
    logic           r_dv_vld [QB];
    tss_pkg::t_meta r_dv_meta [QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QB; i++) begin
                r_dv_vld[i] <= 1'b0;
            end
        end else begin
            r_dv_vld[0] <= r4_vld;
            for (int i = 1; i < QB; i++) begin
                r_dv_vld[i] <= r_dv_vld[i-1];
            end
        end
        r_dv_meta[0] <= r4_meta;
        for (int i = 1; i < QB; i++) begin
            r_dv_meta[i] <= r_dv_meta[i-1];
        end
    end

    function automatic logic [CB-1:0] finish_x(logic signed [CB-1:0] xs, logic neg,
                                              logic [QB-1:0] q);
        logic [XW-1:0] base, mag, x8, ax, rnd;
        base = {{2{xs[CB-1]}}, xs, {FB{1'b0}}};
        mag  = {2'b00, q[CB+FB-1:0]};
        x8   = neg ? (base - mag) : (base + mag);
        ax   = x8[XW-1] ? -x8 : x8;
        rnd  = (ax + (XW'(1) << (FB - 1))) >> FB;
        rnd  = x8[XW-1] ? -rnd : rnd;
        return rnd[CB-1:0];
    endfunction

    function automatic logic [DB-1:0] finish_d(logic [DB-1:0] ds, logic neg,
                                              logic [QB-1:0] q);
        logic [DB+1:0] base, mag, sum;
        base = {2'b00, ds};
        mag  = {2'b00, q[DB-1:0]};
        sum  = neg ? (base - mag) : (base + mag);
        return sum[DB-1:0];
    endfunction

    tss_pkg::t_meta     fm;
    tss_pkg::t_out_word n_word;
    logic [CB-1:0]      xa, xb;
    logic [DB-1:0]      da, db;

    always_comb begin
        fm = r_dv_meta[QB-1];
        xa = finish_x(fm.xs_a, fm.nx_a, q_xa);
        xb = finish_x(fm.xs_b, fm.nx_b, q_xb);
        da = finish_d(fm.ds_a, fm.nd_a, q_da);
        db = finish_d(fm.ds_b, fm.nd_b, q_db);
        n_word.row_inside = fm.on_row;
        n_word.degenerate = fm.degen;
        if (!fm.on_row) begin
            n_word.edge_a_x     = '0;
            n_word.edge_b_x     = '0;
            n_word.edge_a_depth = '0;
            n_word.edge_b_depth = '0;
        end else if (fm.swap) begin
            // flat top: edges come out in the opposite order
            n_word.edge_a_x     = xb;
            n_word.edge_b_x     = xa;
            n_word.edge_a_depth = db;
            n_word.edge_b_depth = da;
        end else begin
            n_word.edge_a_x     = xa;
            n_word.edge_b_x     = xb;
            n_word.edge_a_depth = da;
            n_word.edge_b_depth = db;
        end
    end

    logic               r_out_vld;
    tss_pkg::t_out_word r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_dv_vld[QB-1];
        end
        r_out_word <= n_word;
    end

    assign o_strobe = r_out_vld;
    assign o_word   = r_out_word;

endmodule

@@ sim/tb_triangle_scanline_span_top.sv @@
// ----------------------------------------------------------------------------
// tb_triangle_scanline_span_top
// Self-checking bench for the triangle scanline span pipeline: directed table
// of corner triangles, then random triangles and rows, every result word
// compared with a behavioural prediction of the sorted-vertex span.
// ----------------------------------------------------------------------------
module tb_triangle_scanline_span_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = tss_pkg::CoordBits;
    localparam int DB = tss_pkg::DepthBits;
    localparam int NumRandom = 1130;
    localparam int SettleCycles = 40;
    localparam longint CycleLimit = 200000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    tss_pkg::t_in_word  i_word;
    logic               o_strobe;
    tss_pkg::t_out_word o_word;

    tss_pkg::t_out_word span_q[$];
    int                 n_errors = 0;
    longint             n_cycles = 0;

    typedef struct {
        tss_pkg::t_in_word  w;
        bit                 known;
        tss_pkg::t_out_word res;
    } t_row;
    t_row dir_rows[$];

    triangle_scanline_span_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_word  (i_word),
        .o_strobe(o_strobe),
        .o_word  (o_word)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic longint round_div(longint num, longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint cross_x(longint xs, longint xe, longint d, longint h);
        longint x8;
        x8 = xs * 256 + ((xe - xs) * d * 256) / h;
        if (x8 >= 0) return (x8 + 128) / 256;
        return -((-x8 + 128) / 256);
    endfunction

    function automatic tss_pkg::t_out_word predict_span(tss_pkg::t_in_word w);
        longint vx[3], vy[3], vd[3];
        longint row, t, d, ha, hb, ax, bx, ad, bd;
        int lo, hi;
        tss_pkg::t_out_word r;
        vx[0] = w.vertex0_x; vy[0] = w.vertex0_y; vd[0] = w.vertex0_depth;
        vx[1] = w.vertex1_x; vy[1] = w.vertex1_y; vd[1] = w.vertex1_depth;
        vx[2] = w.vertex2_x; vy[2] = w.vertex2_y; vd[2] = w.vertex2_depth;
        row = w.scan_row;
        r = '0;
        ax = 0; bx = 0; ad = 0; bd = 0;
        if (vy[0] == vy[1] && vy[1] == vy[2]) begin
            r.degenerate = 1'b1;
            lo = 0; hi = 0;
            for (int i = 1; i < 3; i++) begin
                if (vx[i] < vx[lo]) lo = i;
                if (vx[i] > vx[hi]) hi = i;
            end
            if (row == vy[0]) begin
                r.row_inside = 1'b1;
                ax = vx[lo]; ad = vd[lo]; bx = vx[hi]; bd = vd[hi];
            end
        end else begin
            for (int k = 0; k < 3; k++) begin
                int a;
                a = (k == 1) ? 1 : 0;
                if (vy[a] > vy[a+1]) begin
                    t = vx[a]; vx[a] = vx[a+1]; vx[a+1] = t;
                    t = vy[a]; vy[a] = vy[a+1]; vy[a+1] = t;
                    t = vd[a]; vd[a] = vd[a+1]; vd[a+1] = t;
                end
            end
            if (row >= vy[0] && row <= vy[2]) begin
                r.row_inside = 1'b1;
                if (vy[0] < vy[1] && row <= vy[1]) begin
                    d = row - vy[0]; ha = vy[1] - vy[0]; hb = vy[2] - vy[0];
                    ax = cross_x(vx[0], vx[1], d, ha);
                    ad = vd[0] + round_div((vd[1] - vd[0]) * d, ha);
                    bx = cross_x(vx[0], vx[2], d, hb);
                    bd = vd[0] + round_div((vd[2] - vd[0]) * d, hb);
                end else begin
                    d = vy[2] - row; ha = vy[2] - vy[1]; hb = vy[2] - vy[0];
                    ax = cross_x(vx[2], vx[1], d, ha);
                    ad = vd[2] + round_div((vd[1] - vd[2]) * d, ha);
                    bx = cross_x(vx[2], vx[0], d, hb);
                    bd = vd[2] + round_div((vd[0] - vd[2]) * d, hb);
                    // flat top: edges come out swapped
                    if (vy[0] == vy[1]) begin
                        t = ax; ax = bx; bx = t;
                        t = ad; ad = bd; bd = t;
                    end
                end
            end
        end
        r.edge_a_x = ax[CB-1:0];
        r.edge_b_x = bx[CB-1:0];
        r.edge_a_depth = ad[DB-1:0];
        r.edge_b_depth = bd[DB-1:0];
        return r;
    endfunction

    function automatic tss_pkg::t_in_word make_tri(int x0, int y0, int d0,
                                                   int x1, int y1, int d1,
                                                   int x2, int y2, int d2, int row);
        tss_pkg::t_in_word w;
        w.vertex0_x = CB'(x0); w.vertex0_y = CB'(y0); w.vertex0_depth = DB'(d0);
        w.vertex1_x = CB'(x1); w.vertex1_y = CB'(y1); w.vertex1_depth = DB'(d1);
        w.vertex2_x = CB'(x2); w.vertex2_y = CB'(y2); w.vertex2_depth = DB'(d2);
        w.scan_row = CB'(row);
        return w;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    task automatic add_row(tss_pkg::t_in_word w, bit known, tss_pkg::t_out_word res);
        t_row r;
        r.w = w; r.known = known; r.res = res;
        dir_rows.push_back(r);
    endtask

    // one command word, with a random gap ahead of it; start is left high
    task automatic send_word(tss_pkg::t_in_word w, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (busy);
        span_q.push_back(predict_span(w));
        @(negedge i_clk);
    endtask

    function automatic tss_pkg::t_in_word rand_tri();
        tss_pkg::t_in_word w;
        logic [191:0] raw;
        int lo, hi, base;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(tss_pkg::t_in_word)-1:0];
        case ($urandom_range(0, 5))
            0: ;
            1, 2: begin
                // small triangle, row near it
                base = $urandom_range(0, 4000) - 2000;
                w.vertex0_y = CB'(base + $urandom_range(0, 40));
                w.vertex1_y = CB'(base + $urandom_range(0, 40));
                w.vertex2_y = CB'(base + $urandom_range(0, 40));
                w.vertex0_x = CB'(base + $urandom_range(0, 40));
                w.vertex1_x = CB'(base + $urandom_range(0, 40));
                w.vertex2_x = CB'(base + $urandom_range(0, 40));
                w.scan_row = CB'(base + $urandom_range(0, 44) - 2);
            end
            3: begin
                w.vertex1_y = w.vertex0_y;
                if ($urandom_range(0, 1)) w.vertex2_y = w.vertex0_y;
            end
            default: ;
        endcase
        // mostly pick a row within the y range
        if ($urandom_range(0, 3) != 0) begin
            lo = w.vertex0_y; hi = w.vertex0_y;
            if (w.vertex1_y < lo) lo = w.vertex1_y;
            if (w.vertex2_y < lo) lo = w.vertex2_y;
            if (w.vertex1_y > hi) hi = w.vertex1_y;
            if (w.vertex2_y > hi) hi = w.vertex2_y;
            w.scan_row = CB'(lo + $urandom_range(0, hi - lo));
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        tss_pkg::t_out_word want;
        n_cycles <= n_cycles + 1;
        if (i_rst_n && o_strobe) begin
            if (span_q.size() == 0) begin
                $display("unexpected result word");
                n_errors++;
            end else begin
                want = span_q.pop_front();
                if (o_word.row_inside !== want.row_inside)
                    report_mismatch("row_inside", o_word.row_inside, want.row_inside);
                if (o_word.edge_a_x !== want.edge_a_x)
                    report_mismatch("edge_a_x", o_word.edge_a_x, want.edge_a_x);
                if (o_word.edge_b_x !== want.edge_b_x)
                    report_mismatch("edge_b_x", o_word.edge_b_x, want.edge_b_x);
                if (o_word.edge_a_depth !== want.edge_a_depth)
                    report_mismatch("edge_a_depth", o_word.edge_a_depth, want.edge_a_depth);
                if (o_word.edge_b_depth !== want.edge_b_depth)
                    report_mismatch("edge_b_depth", o_word.edge_b_depth, want.edge_b_depth);
                if (o_word.degenerate !== want.degenerate)
                    report_mismatch("degenerate", o_word.degenerate, want.degenerate);
            end
        end
        if (n_cycles >= CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        tss_pkg::t_out_word r;
        tss_pkg::t_in_word w;
        int gap;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_word = '0;

        // outside row: all zero
        r = '0;
        add_row(make_tri(0, 0, 10, 5, 10, 20, -5, 20, 30, 21), 1, r);
        add_row(make_tri(0, 0, 10, 5, 10, 20, -5, 20, 30, -1), 1, r);
        // all y equal, off row
        r = '0; r.degenerate = 1'b1;
        add_row(make_tri(3, 7, 1, 9, 7, 2, -4, 7, 3, 8), 1, r);
        // all y equal, on row, ties go to earliest vertex
        r = '0; r.degenerate = 1'b1; r.row_inside = 1'b1;
        r.edge_a_x = CB'(-4); r.edge_a_depth = DB'(3);
        r.edge_b_x = CB'(9); r.edge_b_depth = DB'(2);
        add_row(make_tri(3, 7, 1, 9, 7, 2, -4, 7, 3, 7), 1, r);
        r.edge_a_x = CB'(5); r.edge_a_depth = DB'(11);
        r.edge_b_x = CB'(5); r.edge_b_depth = DB'(11);
        add_row(make_tri(5, -2048, 11, 5, -2048, 12, 5, -2048, 13, -2048), 1, r);
        // extremes of the coordinate and depth ranges
        r = '0; r.row_inside = 1'b1;
        r.edge_a_x = CB'(-2048); r.edge_b_x = CB'(-2048);
        r.edge_a_depth = 24'hFFFFFF; r.edge_b_depth = 24'hFFFFFF;
        add_row(make_tri(-2048, -2048, 24'hFFFFFF, 2047, 2047, 0, -2048, 2047, 0, -2048),
                1, r);
        add_row(make_tri(-2048, -2048, 24'hFFFFFF, 2047, 2047, 0, -2048, 2047, 0, 2047), 0, r);
        add_row(make_tri(2047, 2047, 0, -2048, -2048, 24'hFFFFFF, 2047, 0, 123, 0), 0, r);
        add_row(make_tri(2047, 2047, 0, -2048, -2048, 24'hFFFFFF, 2047, 0, 123, 1), 0, r);
        // flat top, flat bottom, middle row, halves
        add_row(make_tri(0, 0, 100, 10, 0, 200, 5, 10, 300, 0), 0, r);
        add_row(make_tri(0, 0, 100, 10, 0, 200, 5, 10, 300, 4), 0, r);
        add_row(make_tri(5, 0, 300, 0, 10, 100, 10, 10, 200, 10), 0, r);
        add_row(make_tri(5, 0, 300, 0, 10, 100, 10, 10, 200, 3), 0, r);
        add_row(make_tri(0, 0, 0, 20, 5, 1000, 3, 20, 500, 5), 0, r);
        add_row(make_tri(0, 0, 0, 20, 5, 1000, 3, 20, 500, 6), 0, r);
        add_row(make_tri(3, 20, 500, 20, 5, 1000, 0, 0, 0, 13), 0, r);
        // rounding of halves, negative x
        add_row(make_tri(0, 0, 0, -1, 2, 3, 1, 2, 5, 1), 0, r);
        add_row(make_tri(-3, 0, 7, -4, 4, 0, 0, 8, 2, 2), 0, r);
        add_row(make_tri(-2048, 2047, 0, 2047, -2048, 24'hFFFFFF, 0, 0, 8388608, 1000), 0, r);
        // equal y in the first and third vertex, for the sort
        add_row(make_tri(1, 9, 1, 2, 3, 2, 3, 9, 3, 5), 0, r);
        add_row(make_tri(1, 3, 1, 2, 9, 2, 3, 3, 3, 5), 0, r);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].w, $urandom_range(0, 2));
            // typed-in results must agree with the predictor as well
            if (dir_rows[i].known && span_q[$] !== dir_rows[i].res) begin
                $display("table entry %0d disagrees with prediction", i);
                n_errors++;
            end
        end
        start <= 1'b0;

        // drain before the random part
        wait (span_q.size() == 0);
        @(negedge i_clk);

        for (int n = 0; n < NumRandom; n++) begin
            w = rand_tri();
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
            if ((n / 200) % 2 == 1) gap = 0;
            send_word(w, gap);
            if (n == NumRandom / 2) begin
                start <= 1'b0;
                wait (span_q.size() == 0);
                @(negedge i_clk);
            end
        end
        start <= 1'b0;

        wait (span_q.size() == 0);
        repeat (SettleCycles) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
